### hdl/brb_pkg.sv
// Package for the byte ring buffer: item and result types, operation codes,
// controller states and default sizes. Depends on nothing.
package brb_pkg;

    localparam int DEPTH_DEF     = 1024;
    localparam int MAX_BLOCK_DEF = 8;
    localparam int LEN_W         = 4;
    localparam int DATA_W        = 64;
    localparam int FILL_W        = 11;
    localparam int CAP_W         = 11;
    localparam int APB_DW        = 32;
    localparam int APB_AW        = 3;

    // Register index, taken from paddr[2].
    localparam logic REG_CAPACITY = 1'b0;

    typedef enum logic [1:0] {
        OP_PUT     = 2'd0,
        OP_GET     = 2'd1,
        OP_PEEK    = 2'd2,
        OP_ADVANCE = 2'd3
    } t_op;

    typedef struct packed {
        t_op                operation;
        logic [LEN_W-1:0]   block_length;
        logic [DATA_W-1:0]  write_data;
    } t_in_item;

    typedef struct packed {
        logic               status;
        logic [DATA_W-1:0]  read_data;
        logic [FILL_W-1:0]  fill_level;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WRITE,
        ST_READ,
        ST_WAIT,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic [CAP_W-1:0] capacity;
        logic             clear;
    } t_cfg;

endpackage

### hdl/brb_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// Depends on nothing.
module brb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/brb_cfg.sv
// Configuration register file of the byte ring buffer (capacity register).
// Depends on brb_pkg.
module brb_cfg #(
    parameter int DEPTH = brb_pkg::DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [brb_pkg::APB_AW-1:0]  paddr,
    input  logic [brb_pkg::APB_DW-1:0]  pwdata,
    output logic [brb_pkg::APB_DW-1:0]  prdata,
    output logic                        pready,
    output brb_pkg::t_cfg               o_cfg
);
    import brb_pkg::*;

    // The largest capacity the register can hold.
    localparam int CAP_MAX = (DEPTH > 2047) ? 2047 : DEPTH;

    logic [CAP_W-1:0] r_capacity;
    logic [CAP_W-1:0] n_capacity;
    logic             w_write;
    logic             w_sel_cap;
    logic [CAP_W-1:0] w_value;

    assign w_write   = psel && penable && pwrite && pready;
    assign w_sel_cap = (paddr[2] == REG_CAPACITY);
    assign w_value   = pwdata[CAP_W-1:0];

    always_comb begin
        n_capacity = r_capacity;
        if (w_write && w_sel_cap) begin
            priority if (w_value == '0) begin
                n_capacity = CAP_W'(1);
            end else if ({21'b0, w_value} > 32'(CAP_MAX)) begin
                n_capacity = CAP_W'(CAP_MAX);
            end else begin
                n_capacity = w_value;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_W'(CAP_MAX);
        end else begin
            r_capacity <= n_capacity;
        end
    end

    assign pready         = 1'b1;
    assign prdata         = w_sel_cap ? APB_DW'(r_capacity) : '0;
    assign o_cfg.capacity = r_capacity;
    assign o_cfg.clear    = w_write && w_sel_cap;

endmodule

### hdl/byte_ring_buffer_blocks.sv
// Top level of the byte ring buffer with block put, get, peek and advance.
// Depends on brb_pkg, brb_ram and brb_cfg.
//
// Each item is one block operation of up to MAX_BLOCK bytes on a circular
// byte store. The bytes live in one byte-wide RAM and a small sequencer
// walks them one byte per cycle. An item is taken when start is high and
// busy is low. A refused, zero-length or advance item goes straight to the
// finish state; a put writes its bytes and then finishes, and a get or
// peek reads its bytes and waits for the RAM read of the last byte before it
// finishes. The result appears on o_result for exactly one
// cycle, marked by o_result_valid, in the cycle after the item finishes;
// the receiver cannot stall it, so it must take every result as it comes.
// busy is already low in that cycle, so the next item can be taken at once.
// Writing the capacity register empties the buffer; it should only be
// written while busy is low and no result is pending. The store contents
// are not cleared at reset and need no clearing pass, since only bytes that
// were put are ever read back.
module byte_ring_buffer_blocks #(
    parameter int DEPTH     = brb_pkg::DEPTH_DEF,
    parameter int MAX_BLOCK = brb_pkg::MAX_BLOCK_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  brb_pkg::t_in_item           i_item,
    output logic                        o_result_valid,
    output brb_pkg::t_out_item          o_result,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [brb_pkg::APB_AW-1:0]  paddr,
    input  logic [brb_pkg::APB_DW-1:0]  pwdata,
    output logic [brb_pkg::APB_DW-1:0]  prdata,
    output logic                        pready
);
    import brb_pkg::*;

    localparam int AW = $clog2(DEPTH);
    // Wide enough for a pointer plus a block length, and for the capacity.
    localparam int SW = ((AW > CAP_W) ? AW : CAP_W) + 1;

    // Advance a pointer by n bytes, wrapping at the capacity.
    function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0]    idx,
                                               input logic [LEN_W-1:0] n,
                                               input logic [CAP_W-1:0] cap);
        logic [SW-1:0] s;
        s = SW'(idx) + SW'(n);
        if (s >= SW'(cap)) begin
            s = s - SW'(cap);
        end
        return s[AW-1:0];
    endfunction

    // Configuration.
    t_cfg w_cfg;

    brb_cfg #(
        .DEPTH(DEPTH)
    ) u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Control registers.
    t_state           r_state, n_state;
    logic [AW-1:0]    r_head, n_head;
    logic [AW-1:0]    r_tail, n_tail;
    logic [FILL_W-1:0] r_fill, n_fill;
    logic             r_rd_en, n_rd_en;
    logic             r_res_valid, n_res_valid;

    // Payload registers.
    t_op              r_op, n_op;
    logic [LEN_W-1:0] r_len, n_len;
    logic [DATA_W-1:0] r_wdata, n_wdata;
    logic [DATA_W-1:0] r_rdata, n_rdata;
    logic [LEN_W-1:0] r_cnt, n_cnt;
    logic [AW-1:0]    r_ptr, n_ptr;
    logic             r_refused, n_refused;
    logic [2:0]       r_rd_idx, n_rd_idx;
    t_out_item        r_result, n_result;

    // Sequencer outputs.
    logic             w_ram_we;
    logic             w_rd_issue;
    logic             w_commit;
    logic [7:0]       w_ram_q;

    // Decisions on the item at the port.
    logic             w_accept;
    logic             w_refuse_now;
    logic             w_last;
    logic [AW-1:0]    w_end_ptr;

    assign w_accept = start && !busy;

    always_comb begin
        priority if (int'(i_item.block_length) > MAX_BLOCK) begin
            w_refuse_now = 1'b1;
        end else if (i_item.operation == OP_PUT) begin
            w_refuse_now = ({1'b0, r_fill} + (FILL_W+1)'(i_item.block_length))
                           > {1'b0, w_cfg.capacity};
        end else begin
            w_refuse_now = r_fill < FILL_W'(i_item.block_length);
        end
    end

    assign w_last    = (r_cnt + LEN_W'(1)) == r_len;
    assign w_end_ptr = wrap_add((r_op == OP_PUT) ? r_tail : r_head, r_len, w_cfg.capacity);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    priority if (w_refuse_now || i_item.block_length == '0 ||
                                 i_item.operation == OP_ADVANCE) begin
                        n_state = ST_FINISH;
                    end else if (i_item.operation == OP_PUT) begin
                        n_state = ST_WRITE;
                    end else begin
                        n_state = ST_READ;
                    end
                end
            end
            ST_WRITE:  n_state = w_last ? ST_FINISH : ST_WRITE;
            ST_READ:   n_state = w_last ? ST_WAIT : ST_READ;
            ST_WAIT:   n_state = ST_FINISH;
            ST_FINISH: n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        w_ram_we   = 1'b0;
        w_rd_issue = 1'b0;
        w_commit   = 1'b0;
        unique case (r_state)
            ST_IDLE:   ;
            ST_WRITE:  w_ram_we   = 1'b1;
            ST_READ:   w_rd_issue = 1'b1;
            ST_WAIT:   ;
            ST_FINISH: w_commit   = 1'b1;
            default:   ;
        endcase
    end

    assign busy = (r_state != ST_IDLE);

    brb_ram #(
        .WIDTH(8),
        .DEPTH(DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_ptr),
        .i_wdata (r_wdata[7:0]),
        .i_raddr (r_ptr),
        .o_rdata (w_ram_q)
    );

    // Datapath next values.
    always_comb begin
        n_head      = r_head;
        n_tail      = r_tail;
        n_fill      = r_fill;
        n_op        = r_op;
        n_len       = r_len;
        n_wdata     = r_wdata;
        n_rdata     = r_rdata;
        n_cnt       = r_cnt;
        n_ptr       = r_ptr;
        n_refused   = r_refused;
        n_rd_en     = w_rd_issue;
        n_rd_idx    = r_cnt[2:0];
        n_res_valid = w_commit;
        n_result    = r_result;

        if (w_accept) begin
            n_op      = i_item.operation;
            n_len     = i_item.block_length;
            n_wdata   = i_item.write_data;
            n_rdata   = '0;
            n_cnt     = '0;
            n_ptr     = (i_item.operation == OP_PUT) ? r_tail : r_head;
            n_refused = w_refuse_now;
        end

        // A byte read issued last cycle lands in its lane now.
        if (r_rd_en) begin
            n_rdata[8*r_rd_idx +: 8] = w_ram_q;
        end

        if (w_ram_we || w_rd_issue) begin
            n_ptr = wrap_add(r_ptr, LEN_W'(1), w_cfg.capacity);
            n_cnt = r_cnt + LEN_W'(1);
        end
        if (w_ram_we) begin
            n_wdata = r_wdata >> 8;
        end

        if (w_commit) begin
            if (!r_refused) begin
                unique case (r_op)
                    OP_PUT: begin
                        n_tail = w_end_ptr;
                        n_fill = r_fill + FILL_W'(r_len);
                    end
                    OP_GET, OP_ADVANCE: begin
                        n_head = w_end_ptr;
                        n_fill = r_fill - FILL_W'(r_len);
                    end
                    OP_PEEK: ;
                endcase
            end
            n_result.status     = r_refused;
            n_result.read_data  = r_refused ? '0 : r_rdata;
            n_result.fill_level = n_fill;
        end

        // A capacity write empties the buffer.
        if (w_cfg.clear) begin
            n_head = '0;
            n_tail = '0;
            n_fill = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_fill      <= '0;
            r_rd_en     <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_fill      <= n_fill;
            r_rd_en     <= n_rd_en;
            r_res_valid <= n_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_len     <= n_len;
        r_wdata   <= n_wdata;
        r_rdata   <= n_rdata;
        r_cnt     <= n_cnt;
        r_ptr     <= n_ptr;
        r_refused <= n_refused;
        r_rd_idx  <= n_rd_idx;
        r_result  <= n_result;
    end

    assign o_result_valid = r_res_valid;
    assign o_result       = r_result;

    // Every finished item yields its result in the following cycle.
    a_finish_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_FINISH |=> o_result_valid)
        else $error("finished item gave no result");

    // A refused item never carries read data.
    a_refused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_result.status) |-> (o_result.read_data == '0))
        else $error("refused result carries data");

    // The stored byte count stays within the configured capacity.
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= w_cfg.capacity)
        else $error("fill count above capacity");

    // Only a put writes the store.
    a_write_is_put: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ram_we |-> (r_op == OP_PUT && !r_refused))
        else $error("store written outside a put");

    // A taken item holds the block busy in the next cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> busy)
        else $error("item taken but block not busy");

endmodule

### bench/byte_ring_buffer_blocks_tb.sv
// Self-checking testbench for byte_ring_buffer_blocks: directed and random block operations
// over several capacity settings, checked against a predictor of the ring buffer.
// Depends on brb_pkg and the byte_ring_buffer_blocks RTL.
module byte_ring_buffer_blocks_tb;
    import brb_pkg::*;

    localparam int HALF_PERIOD   = 2;
    localparam int RESET_CYCLES  = 10;
    localparam int CYCLE_LIMIT   = 400000;
    // The longest item is an eight-byte get or peek, and this many quiet cycles
    // after it are ample before a register write or the end.
    localparam int SETTLE_CYCLES = 16;
    localparam int MAX_GAP       = 6;
    localparam int RING_AW       = $clog2(DEPTH_DEF);

    // An item waiting to be driven, with the number of idle cycles that precede it.
    typedef struct packed {
        t_in_item   item;
        logic [2:0] gap;
    } t_pending;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                start = 1'b0;
    logic                busy;
    t_in_item            i_item = '0;
    logic                o_result_valid;
    t_out_item           o_result;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [APB_AW-1:0]   paddr;
    logic [APB_DW-1:0]   pwdata;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    byte_ring_buffer_blocks dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_item         (i_item),
        .o_result_valid (o_result_valid),
        .o_result       (o_result),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always #(HALF_PERIOD) i_clk = ~i_clk;

    // Items still to be driven, and the results that the buffer is expected to give.
    t_pending    item_queue[$];
    t_out_item   awaited_results[$];

    int unsigned items_queued = 0;
    int unsigned results_seen = 0;
    int unsigned error_count  = 0;
    int unsigned cycle_count  = 0;
    int unsigned gap_count    = 0;
    int unsigned burst_left   = 0;
    bit          no_idle      = 1'b0;
    // Set at each rising edge when the item on the inputs was taken.
    bit          item_taken   = 1'b0;

    // Our own copy of the ring buffer: byte store, pointers, fill and capacity.
    logic [7:0]  ring_bytes [DEPTH_DEF];
    int unsigned ring_head;
    int unsigned ring_tail;
    int unsigned ring_fill;
    int unsigned ring_cap;

    // Advances a pointer by n slots, wrapping by one conditional subtraction.
    function automatic int unsigned ring_next(int unsigned idx, int unsigned n);
        int unsigned s;
        s = idx + n;
        if (s >= ring_cap) begin
            s -= ring_cap;
        end
        return s;
    endfunction

    // A capacity write is clamped to 1..DEPTH and always leaves the buffer empty.
    function automatic void set_capacity(logic [APB_DW-1:0] value);
        int unsigned v;
        v = 32'(value[CAP_W-1:0]);
        if (v == 0) begin
            v = 1;
        end
        if (v > DEPTH_DEF) begin
            v = DEPTH_DEF;
        end
        ring_cap  = v;
        ring_head = 0;
        ring_tail = 0;
        ring_fill = 0;
    endfunction

    // Carries out one block operation on the copy and returns the result it gives.
    // Every operation is all-or-nothing, so a refusal leaves the copy untouched.
    function automatic t_out_item apply_block_op(t_in_item it);
        t_out_item   res;
        int unsigned len;
        int unsigned p;
        int          i;
        res = '0;
        len = 32'(it.block_length);
        if (len > MAX_BLOCK_DEF) begin
            res.status = 1'b1;
        end else if (it.operation == OP_PUT) begin
            if (ring_fill + len > ring_cap) begin
                res.status = 1'b1;
            end else begin
                p = ring_tail;
                for (i = 0; i < len; i++) begin
                    ring_bytes[p[RING_AW-1:0]] = it.write_data[8*i +: 8];
                    p = ring_next(p, 1);
                end
                ring_tail = ring_next(ring_tail, len);
                ring_fill += len;
            end
        end else if (ring_fill < len) begin
            res.status = 1'b1;
        end else begin
            p = ring_head;
            if (it.operation != OP_ADVANCE) begin
                for (i = 0; i < len; i++) begin
                    res.read_data[8*i +: 8] = ring_bytes[p[RING_AW-1:0]];
                    p = ring_next(p, 1);
                end
            end
            if (it.operation != OP_PEEK) begin
                ring_head = ring_next(ring_head, len);
                ring_fill -= len;
            end
        end
        res.fill_level = FILL_W'(ring_fill);
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("MISMATCH at cycle %0d: %s: got %h, want %h", cycle_count, what, got, want);
        error_count++;
    endtask

    // Queues one item. The idle gap before it is drawn from 0 to MAX_GAP, except
    // in stretches where the sender runs flat out with no gaps at all.
    function automatic void queue_item(t_op op, int unsigned len, logic [63:0] data);
        t_pending p;
        if (burst_left == 0) begin
            no_idle    = ($urandom_range(0, 2) == 0);
            burst_left = $urandom_range(5, 40);
        end
        burst_left--;
        p.item.operation    = op;
        p.item.block_length = LEN_W'(len);
        p.item.write_data   = data;
        p.gap = no_idle ? 3'd0 : 3'($urandom_range(0, MAX_GAP));
        item_queue.push_back(p);
        items_queued++;
    endfunction

    // A random item: mostly legal lengths, with puts weighted by put_pct so that the
    // fill level can be steered towards full or empty, and a little noise of
    // over-long operations that must be refused.
    function automatic void queue_random(int unsigned put_pct);
        t_op              op;
        int unsigned      len;
        logic [63:0]      data;
        int unsigned      pick;
        pick = $urandom_range(0, 99);
        if (pick < 5) begin
            op  = t_op'($urandom_range(0, 3));
            len = $urandom_range(MAX_BLOCK_DEF + 1, 15);
        end else begin
            if ($urandom_range(0, 99) < put_pct) begin
                op = OP_PUT;
            end else begin
                op = t_op'($urandom_range(1, 3));
            end
            len = $urandom_range(0, MAX_BLOCK_DEF);
        end
        pick = $urandom_range(0, 19);
        if (pick == 0) begin
            data = '1;
        end else if (pick == 1) begin
            data = '0;
        end else begin
            data = {$urandom, $urandom};
        end
        queue_item(op, len, data);
    endfunction

    // Waits until every queued item has given its result and the block is idle,
    // then lets a few more cycles pass so that nothing can still be in flight.
    task automatic wait_idle();
        @(negedge i_clk);
        while (results_seen != items_queued || busy) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // One APB write: a setup cycle, then an access cycle held until pready.
    task automatic write_capacity(logic [APB_DW-1:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {REG_CAPACITY, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // A phase optionally rewrites the capacity while the block is idle, then runs
    // a batch of random items and waits for all of their results.
    task automatic run_phase(bit write_cap, logic [APB_DW-1:0] cap_value,
                             int unsigned n_items, int unsigned put_pct);
        if (write_cap) begin
            wait_idle();
            write_capacity(cap_value);
        end
        repeat (n_items) queue_random(put_pct);
        wait_idle();
    endtask

    // Driver. Inputs change on the falling edge. An item stays on the inputs with
    // start high until it is taken; the next one follows after its own gap, and
    // with no gap start simply stays high.
    always @(negedge i_clk) begin
        if (!(start && !item_taken)) begin
            if (item_queue.size() != 0 && gap_count >= item_queue[0].gap) begin
                i_item    <= item_queue[0].item;
                item_queue.pop_front();
                start     <= 1'b1;
                gap_count = 0;
            end else begin
                start     <= 1'b0;
                gap_count++;
            end
        end
    end

    // Monitor. All outputs are sampled on the rising edge, before the block
    // updates them. A result is checked against the oldest expectation first, so
    // an item taken on the same edge queues its expectation behind it.
    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            set_capacity(APB_DW'(DEPTH_DEF));
            item_taken = 1'b0;
        end else begin
            if (o_result_valid) begin
                if (awaited_results.size() == 0) begin
                    report_mismatch("result with nothing awaited", o_result.read_data,
                                    64'd0);
                end else begin
                    want = awaited_results.pop_front();
                    if (o_result.status !== want.status) begin
                        report_mismatch("status", 64'(o_result.status), 64'(want.status));
                    end
                    if (o_result.read_data !== want.read_data) begin
                        report_mismatch("read_data", o_result.read_data, want.read_data);
                    end
                    if (o_result.fill_level !== want.fill_level) begin
                        report_mismatch("fill_level", 64'(o_result.fill_level),
                                        64'(want.fill_level));
                    end
                    results_seen++;
                end
            end
            item_taken = start && !busy;
            if (item_taken) begin
                awaited_results.push_back(apply_block_op(i_item));
            end
            // The register takes the write on this edge, so the copy follows suit.
            if (psel && penable && pwrite && pready && paddr[2] == REG_CAPACITY) begin
                set_capacity(pwdata);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        i_rst_n = 1'b0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part at the reset capacity. Reads of an empty buffer are refused,
        // zero-length operations of every kind succeed and change nothing, and
        // lengths above the largest block are refused whatever the fill.
        queue_item(OP_GET, 1, {$urandom, $urandom});
        queue_item(OP_PEEK, 8, '0);
        queue_item(OP_ADVANCE, 1, '0);
        queue_item(OP_PUT, 0, '1);
        queue_item(OP_GET, 0, '0);
        queue_item(OP_PEEK, 0, '0);
        queue_item(OP_ADVANCE, 0, '0);
        queue_item(OP_PUT, 8, '1);
        queue_item(OP_PUT, 15, '1);
        queue_item(OP_PUT, 9, {$urandom, $urandom});
        queue_item(OP_PEEK, 8, '0);
        queue_item(OP_GET, 3, '0);
        queue_item(OP_PUT, 8, '0);
        queue_item(OP_PUT, 5, {$urandom, $urandom});
        queue_item(OP_PEEK, 9, '0);
        queue_item(OP_GET, 8, '0);
        queue_item(OP_ADVANCE, 2, '0);
        queue_item(OP_GET, 8, '0);
        queue_item(OP_GET, 1, '0);
        queue_item(OP_PUT, 8, 64'h0123_4567_89AB_CDEF);
        queue_item(OP_PEEK, 4, '0);
        queue_item(OP_ADVANCE, 4, '0);
        queue_item(OP_GET, 4, '0);
        run_phase(1'b0, '0, 150, 55);

        // A capacity of zero behaves as a single slot: one byte fills it.
        wait_idle();
        write_capacity('0);
        queue_item(OP_PUT, 1, {$urandom, $urandom});
        queue_item(OP_PUT, 1, {$urandom, $urandom});
        queue_item(OP_PEEK, 1, '0);
        queue_item(OP_GET, 1, '0);
        queue_item(OP_PUT, 2, {$urandom, $urandom});
        run_phase(1'b0, '0, 60, 50);

        // Too large a capacity saturates to the full store; junk in the upper
        // bits of the write data must be ignored. Fill it to the brim, then drain.
        run_phase(1'b1, {21'($urandom_range(0, 2097151)), 11'h7FF}, 300, 90);
        run_phase(1'b0, '0, 150, 15);

        // Further capacities, mostly small ones that make the pointers wrap all the time.
        run_phase(1'b1, 32'd5, 100, 50);
        run_phase(1'b1, 32'd13, 100, 55);
        run_phase(1'b1, 32'd2, 80, 50);
        run_phase(1'b1, 32'd1023, 120, 80);
        run_phase(1'b1, {21'($urandom_range(0, 2097151)), 11'd9}, 100, 50);
        run_phase(1'b1, $urandom_range(1, 64), 100, 50);
        run_phase(1'b1, APB_DW'(DEPTH_DEF), 80, 50);

        if (awaited_results.size() != 0) begin
            report_mismatch("results never produced", 64'(awaited_results.size()), 64'd0);
        end
        if (error_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
